// ===== hdl/teq_pkg.sv =====
package teq_pkg;

   localparam int DEFAULT_DEPTH = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_FIND   = 2'd3
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic [15:0]        event_type;
      logic [31:0]        due_count;
      logic [31:0]        now_count;
      logic signed [31:0] cycle_credit;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] hit_type;
      logic [31:0] hit_due;
      logic [31:0] next_due;
      logic        queue_empty;
      logic [4:0]  occupancy;
      logic        dropped;
   } rsp_type;

   typedef struct packed {
      logic [15:0] event_type;
      logic [31:0] due_count;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HEAD_READ,
      ST_REPLY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
      logic head_read;
      logic reply;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic at_end;
   } stat_type;

endpackage

// ===== hdl/teq_ctrl.sv =====
module teq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  teq_pkg::stat_type  status,
   output teq_pkg::cmd_type   cmd,
   output logic               busy
);

   teq_pkg::state_type state_ff;
   teq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= teq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         teq_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (accept) begin
               cmd.load = 1'b1;
               state_in = teq_pkg::ST_SCAN;
            end
         end
         teq_pkg::ST_SCAN: begin
            if (status.at_end) begin
               cmd.finish = 1'b1;
               state_in   = teq_pkg::ST_HEAD_READ;
            end else begin
               cmd.step = 1'b1;
            end
         end
         teq_pkg::ST_HEAD_READ: begin
            cmd.head_read = 1'b1;
            state_in      = teq_pkg::ST_REPLY;
         end
         teq_pkg::ST_REPLY: begin
            cmd.reply = 1'b1;
            state_in  = teq_pkg::ST_IDLE;
         end
         default: begin
            state_in = teq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/teq_datapath.sv =====
module teq_datapath #(
   parameter int DEPTH = teq_pkg::DEFAULT_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  teq_pkg::cmd_type   cmd,
   input  teq_pkg::req_type   req_data,
   output teq_pkg::stat_type  status,
   output logic               rsp_strobe,
   output teq_pkg::rsp_type   rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   teq_pkg::entry_type mem [DEPTH];
   teq_pkg::entry_type rd_entry_ff;

   // Control state.
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in;
   logic          strobe_ff, strobe_in;

   // Payload state.
   teq_pkg::op_type    op_ff;
   logic [15:0]        type_ff;
   logic [31:0]        due_ff;
   logic [31:0]        now_ff;
   logic [31:0]        ref_ff;
   logic               drop_ff;
   teq_pkg::entry_type carry_ff, carry_in;
   teq_pkg::entry_type hit_ff, hit_in;
   teq_pkg::rsp_type   rsp_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   teq_pkg::entry_type wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;

   logic [CW-1:0]      idx_plus;
   logic [CW-1:0]      idx_minus;
   logic [31:0]        new_off;
   logic [31:0]        old_off;
   logic               is_earlier;
   logic               is_match;
   teq_pkg::entry_type new_entry;

   assign idx_plus   = idx_ff + CW'(1);
   assign idx_minus  = idx_ff - CW'(1);
   assign new_off    = due_ff - ref_ff;
   assign old_off    = rd_entry_ff.due_count - ref_ff;
   assign is_earlier = new_off < old_off;
   assign new_entry  = '{event_type: type_ff, due_count: due_ff};
   assign status.at_end = (idx_ff == fill_ff);

   always_comb begin
      case (op_ff)
         teq_pkg::OP_POP:    is_match = (idx_ff == '0);
         teq_pkg::OP_REMOVE: is_match = (rd_entry_ff.event_type == type_ff);
         teq_pkg::OP_FIND:   is_match = (rd_entry_ff.event_type == type_ff);
         default:            is_match = 1'b0;
      endcase
   end

   always_comb begin
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      found_in  = found_ff;
      carry_in  = carry_ff;
      hit_in    = hit_ff;
      strobe_in = cmd.reply;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = carry_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;

      if (cmd.load) begin
         idx_in   = '0;
         found_in = 1'b0;
         hit_in   = '0;
         rd_en    = 1'b1;
      end

      if (cmd.step) begin
         idx_in  = idx_plus;
         rd_en   = 1'b1;
         rd_addr = idx_plus[AW-1:0];
         if (op_ff == teq_pkg::OP_INSERT) begin
            if (!drop_ff) begin
               if (!found_ff && is_earlier) begin
                  wr_en    = 1'b1;
                  wr_data  = new_entry;
                  carry_in = rd_entry_ff;
                  found_in = 1'b1;
               end else if (found_ff) begin
                  wr_en    = 1'b1;
                  wr_data  = carry_ff;
                  carry_in = rd_entry_ff;
               end
            end
         end else begin
            if (!found_ff && is_match) begin
               found_in = 1'b1;
               hit_in   = rd_entry_ff;
            end else if (found_ff && op_ff != teq_pkg::OP_FIND) begin
               // Close the gap left by the removed entry.
               wr_en   = 1'b1;
               wr_addr = idx_minus[AW-1:0];
               wr_data = rd_entry_ff;
            end
         end
      end

      if (cmd.finish) begin
         if (op_ff == teq_pkg::OP_INSERT) begin
            if (!drop_ff) begin
               wr_en   = 1'b1;
               wr_addr = fill_ff[AW-1:0];
               wr_data = found_ff ? carry_ff : new_entry;
               fill_in = fill_ff + CW'(1);
            end
         end else if (found_ff && op_ff != teq_pkg::OP_FIND) begin
            fill_in = fill_ff - CW'(1);
         end
      end

      if (cmd.head_read) begin
         rd_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         idx_ff    <= '0;
         found_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         idx_ff    <= idx_in;
         found_ff  <= found_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
      hit_ff   <= hit_in;
      if (cmd.load) begin
         op_ff   <= req_data.operation;
         type_ff <= req_data.event_type;
         due_ff  <= req_data.due_count;
         now_ff  <= req_data.now_count;
         if (req_data.cycle_credit > 32'sd0) begin
            ref_ff <= req_data.now_count - 32'(req_data.cycle_credit);
         end else begin
            ref_ff <= req_data.now_count;
         end
         drop_ff <= (req_data.operation == teq_pkg::OP_INSERT) && (fill_ff == CW'(DEPTH));
      end
      if (cmd.reply) begin
         rsp_ff.hit         <= found_ff && (op_ff != teq_pkg::OP_INSERT);
         rsp_ff.hit_type    <= hit_ff.event_type;
         rsp_ff.hit_due     <= hit_ff.due_count;
         rsp_ff.next_due    <= (fill_ff == '0) ? now_ff : rd_entry_ff.due_count;
         rsp_ff.queue_empty <= (fill_ff == '0);
         rsp_ff.occupancy   <= 5'(fill_ff);
         rsp_ff.dropped     <= drop_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("entry count exceeds the queue depth");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < DEPTH))
      else $error("storage write outside the queue depth");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.dropped) |-> (fill_ff == CW'(DEPTH)))
      else $error("insert dropped while the queue had room");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_drop_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.hit) |-> !rsp_data.dropped)
      else $error("result flags both a hit and a dropped insert");

endmodule

// ===== hdl/timed_event_queue_core.sv =====
// Channel   Ports                           Direction  Transaction
// request   start, busy, req_data           in         start high while busy is low
// result    rsp_strobe, rsp_data            out        one cycle, marked by rsp_strobe
//
// An operation walks over the entries held before it in the entry storage, one entry per
// cycle through a single write port and a single registered read port, then reads the
// head entry and registers the result.
// Reset is synchronous and active high; it empties the queue and returns the controller
// to idle. Entry storage is not cleared, since only entries below the fill count are read.
// The receiver cannot stall: each result appears for exactly one cycle, and busy drops in
// that same cycle so the next transaction may be accepted alongside it.
module timed_event_queue_core #(
   parameter int DEPTH = teq_pkg::DEFAULT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  teq_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output teq_pkg::rsp_type  rsp_data
);

   // A transaction is taken when start is high and the controller is idle.
   logic              accept;
   teq_pkg::cmd_type  cmd;
   teq_pkg::stat_type status;

   assign accept = start && !busy;

   // The controller sequences load, the storage walk, the head read and the reply.
   teq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // The datapath holds the ordered entry storage, the fill count and the result register.
   // Inserts ripple later entries up by one slot as the walk passes them; removals pull
   // later entries down by one slot behind the matched entry.
   teq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
